/* rtl/fmd_pkg.sv */
// ----------------------------------------------------------------------------
// fmd_pkg: shared types and constants for the min-dequeue FIFO
// Command and status codes, cell operations and the payload structs of the
// command and response channels.
// ----------------------------------------------------------------------------
package fmd_pkg;

  localparam int DEPTH_DEF = 512;
  localparam int ITEM_W    = 32;
  localparam int COUNT_W   = 10;

  typedef logic [ITEM_W-1:0]  item_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [1:0] {
    CMD_ENQ = 2'd0,
    CMD_DEQ = 2'd1,
    CMD_MIN = 2'd2,
    CMD_CLR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // What every cell of the chain does this cycle
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_LOAD   = 2'd1,
    OP_SHIFT  = 2'd2,
    OP_ROTATE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cmd_t  command;
    item_t item_in;
  } cmd_item_t;

  typedef struct packed {
    status_t status;
    item_t   item_out;
    count_t  count;
    logic    is_empty;
    logic    is_full;
  } rsp_item_t;

endpackage

/* rtl/fmd_cell.sv */
// ----------------------------------------------------------------------------
// fmd_cell: one storage cell of the entry chain
// Holds one entry. Loads a new item, takes its upper neighbor's entry, or,
// when it is the last live cell of a rotation, takes the head entry.
// ----------------------------------------------------------------------------
module fmd_cell
  import fmd_pkg::*;
#(
  parameter int CNT_W = 10,
  parameter int INDEX = 0
) (
  input  logic             clk,
  input  cell_op_t         op,
  input  logic [CNT_W-1:0] sel,
  input  item_t            next_data,
  input  item_t            head_data,
  input  item_t            new_data,
  output item_t            data
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

  logic hit;

  assign hit = (sel == MY_IDX);

  // Entry register, no reset: contents are only read once written
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        if (hit) begin
          data <= new_data;
        end
      end
      OP_SHIFT:  data <= next_data;
      OP_ROTATE: data <= hit ? head_data : next_data;
      default:   data <= data;
    endcase
  end

endmodule

/* rtl/fmd_ctrl.sv */
// ----------------------------------------------------------------------------
// fmd_ctrl: command sequencer of the min-dequeue FIFO
// Keeps the fill count, drives the cell chain and builds the responses.
// A min dequeue rotates the chain once to find the minimum and once more
// to drop it, restoring oldest-first order at cell zero.
// ----------------------------------------------------------------------------
module fmd_ctrl
  import fmd_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  cmd_item_t        cmd,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rsp_item_t        rsp,
  input  item_t            head,
  output cell_op_t         cell_op,
  output logic [CNT_W-1:0] sel
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ZERO_CNT = '0;
  localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DROP = 3'b100
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] len;
  logic [CNT_W-1:0] step;
  logic [CNT_W-1:0] best_idx;
  item_t            best;
  logic             accept;
  logic             rsp_set;

  function automatic rsp_item_t make_rsp(status_t st, item_t val, logic [CNT_W-1:0] n);
    rsp_item_t r;
    r.status   = st;
    r.item_out = val;
    r.count    = COUNT_W'(n);
    r.is_empty = (n == ZERO_CNT);
    r.is_full  = (n == FULL_CNT);
    return r;
  endfunction

  assign cmd_ready = (state == S_IDLE) && (!rsp_valid || rsp_ready);
  assign accept    = cmd_valid && cmd_ready;

  // Response load: at the transfer, except a non-empty min dequeue at its end
  assign rsp_set = (accept && (cmd.command != CMD_MIN || count == ZERO_CNT)) ||
                   (state == S_DROP && step == count - ONE_CNT);

  // Chain control
  always_comb begin
    cell_op = OP_HOLD;
    sel     = count;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (cmd.command == CMD_ENQ && count != FULL_CNT) begin
            cell_op = OP_LOAD;
          end else if (cmd.command == CMD_DEQ && count != ZERO_CNT) begin
            cell_op = OP_SHIFT;
          end
        end
      end
      S_SCAN: begin
        cell_op = OP_ROTATE;
        sel     = len - ONE_CNT;
      end
      S_DROP: begin
        if (step == best_idx) begin
          cell_op = OP_SHIFT;
        end else begin
          cell_op = OP_ROTATE;
          sel     = len - ONE_CNT;
        end
      end
      default: begin
        cell_op = OP_HOLD;
      end
    endcase
  end

  // Sequencer, count and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= rsp_set || (rsp_valid && !rsp_ready);
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (cmd.command)
              CMD_ENQ: begin
                if (count == FULL_CNT) begin
                  rsp <= make_rsp(STAT_FULL, '0, count);
                end else begin
                  count <= count + ONE_CNT;
                  rsp   <= make_rsp(STAT_DONE, '0, count + ONE_CNT);
                end
              end
              CMD_DEQ: begin
                if (count == ZERO_CNT) begin
                  rsp <= make_rsp(STAT_EMPTY, '0, count);
                end else begin
                  count <= count - ONE_CNT;
                  rsp   <= make_rsp(STAT_DONE, head, count - ONE_CNT);
                end
              end
              CMD_MIN: begin
                if (count == ZERO_CNT) begin
                  rsp <= make_rsp(STAT_EMPTY, '0, count);
                end else begin
                  state <= S_SCAN;
                  len   <= count;
                  step  <= '0;
                end
              end
              default: begin
                count <= '0;
                rsp   <= make_rsp(STAT_DONE, '0, ZERO_CNT);
              end
            endcase
          end
        end
        // Pass one: the last entry at or below the running minimum wins
        S_SCAN: begin
          if (step == ZERO_CNT || head <= best) begin
            best     <= head;
            best_idx <= step;
          end
          if (step == len - ONE_CNT) begin
            state <= S_DROP;
            step  <= '0;
          end else begin
            step <= step + ONE_CNT;
          end
        end
        // Pass two: rotate, dropping the minimum when it reaches cell zero
        S_DROP: begin
          if (step == best_idx) begin
            len <= len - ONE_CNT;
          end
          step <= step + ONE_CNT;
          if (step == count - ONE_CNT) begin
            state <= S_IDLE;
            count <= count - ONE_CNT;
            rsp   <= make_rsp(STAT_DONE, best, count - ONE_CNT);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/fifo_with_min_dequeue.sv */
// ----------------------------------------------------------------------------
// fifo_with_min_dequeue: FIFO with oldest and minimum dequeue
// Enqueue, dequeue and clear: response registered at the command transfer and
//   valid in the next cycle; one command per cycle while responses are taken.
// Min dequeue: two rotations of the cell chain over the N held entries
//   (find, then drop); no new command until it responds.
// Reset clears the state, the count and the response valid flag; cell contents are kept.
// ----------------------------------------------------------------------------
module fifo_with_min_dequeue
  import fmd_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_item_t cmd,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_item_t rsp
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  cell_op_t         cell_op;
  logic [CNT_W-1:0] sel;
  item_t            cell_q [DEPTH];

  // Sequencer
  fmd_ctrl #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .head      (cell_q[0]),
    .cell_op   (cell_op),
    .sel       (sel)
  );

  // Cell chain, oldest entry at cell zero
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    item_t next_d;
    if (i == DEPTH - 1) begin : g_last
      assign next_d = cell_q[0];
    end else begin : g_mid
      assign next_d = cell_q[i+1];
    end
    fmd_cell #(
      .CNT_W (CNT_W),
      .INDEX (i)
    ) u_cell (
      .clk       (clk),
      .op        (cell_op),
      .sel       (sel),
      .next_data (next_d),
      .head_data (cell_q[0]),
      .new_data  (cmd.item_in),
      .data      (cell_q[i])
    );
  end

endmodule

/* rtl/fmd_checker.sv */
// ----------------------------------------------------------------------------
// fmd_checker: port-level checks for the min-dequeue FIFO
// Watches the command and response channels of the top level; bound to it
// at the end of this file.
// ----------------------------------------------------------------------------
module fmd_checker
  import fmd_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      cmd_valid,
  input logic      cmd_ready,
  input cmd_item_t cmd,
  input logic      rsp_valid,
  input logic      rsp_ready,
  input rsp_item_t rsp
);

  // A stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // Commands other than min dequeue respond on the next cycle
  a_quick_rsp: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && cmd.command != CMD_MIN |=> rsp_valid)
    else $error("missing response after single-cycle command");

  // A rejected command returns a zero item
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != STAT_DONE |-> rsp.item_out == '0)
    else $error("rejected command returned an item");

  // Full rejection only while full, empty rejection only while empty
  a_reject_flags: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status != STAT_FULL || rsp.is_full) &&
                  (rsp.status != STAT_EMPTY || rsp.is_empty))
    else $error("rejection status disagrees with flags");

endmodule

bind fifo_with_min_dequeue fmd_checker u_fmd_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_ready (cmd_ready),
  .cmd       (cmd),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
